[rtl/stg_pkg.sv]
// Shared types and constants for the sine tone generator.
// Holds the quarter-wave table entry function used to build the sine ROM.
// No dependencies.
package stg_pkg;

    // Width of the configuration data port and of both registers.
    localparam int CFG_WIDTH = 32;

    // Bits of phase held by one accumulator cell.
    localparam int CELL_BITS = 8;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_PHASE_STEP   = 1'b0,
        CFG_BURST_LENGTH = 1'b1
    } t_cfg_index;

    // Control that every phase cell sees in a cycle.
    typedef struct packed {
        logic load;     // a request is accepted this cycle
        logic clear;    // restart: work from zero phase
        logic zero;     // burst end: phase returns to zero afterwards
    } t_cell_ctl;

    // pi/2 in Q30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Taylor series divisors (2n)(2n+1) for n = 1 to 7.
    localparam logic [6:0][7:0] TAYLOR_DIV = {
        8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };

    // Long division of a 64-bit value by a small divisor, one quotient bit per step.
    function automatic logic [63:0] div_by_small(
        input logic [63:0] num,
        input logic [7:0]  den
    );
        logic [63:0] quo;
        logic [8:0]  rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[7:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // One quarter-wave entry: round(amp * sin(pi/2 * k / 2^addr_bits)), with the
    // sine taken from a Q30 Taylor series. Evaluated at elaboration only.
    function automatic logic [31:0] quarter_entry(
        input logic [31:0] k,
        input int          addr_bits,
        input logic [63:0] amp
    );
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        x    = (HALF_PI_Q30 * {32'd0, k}) >> addr_bits;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = div_by_small(term, TAYLOR_DIV[n-1]);
            if ((n & 1) != 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        v = (sum * signed'(amp) + (64'sd1 <<< 29)) >>> 30;
        if (v > signed'(amp)) begin
            v = signed'(amp);
        end
        return v[31:0];
    endfunction

endpackage

[rtl/sine_tone_generator.sv]
// Sine tone generator: phase accumulator built from a row of carry-linked
// cells, quarter-wave ROM lookup and a two-stage output pipeline.
// Depends on stg_pkg, stg_phase_cell and stg_quarter_rom.
//
//   Channel   Handshake                Payload
//   -------   ----------------------   ----------------------------------
//   input     i_valid / o_stall        i_restart
//   output    o_valid / i_stall        o_sample, o_cycle_end, o_last
//   config    i_cfg_wr_en              i_cfg_idx, i_cfg_wdata
//
// One request is accepted per cycle while o_stall is low; its sample passes
// through the registered ROM read and then the output register.
// Synchronous active-low reset clears phase, burst count, registers and valids.
// The output register and the ROM stage move independently, so a new request
// is taken while a finished sample waits under i_stall, until both are full.
module sine_tone_generator #(
    parameter int PHASE_BITS      = 32,
    parameter int SAMPLE_BITS     = 16,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_restart,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_cycle_end,
    output logic                          o_last,
    input  logic                          i_cfg_wr_en,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [stg_pkg::CFG_WIDTH-1:0] i_cfg_wdata
);

    localparam int CW     = stg_pkg::CELL_BITS;
    localparam int NCELLS = (PHASE_BITS + CW - 1) / CW;
    localparam int MAG_W  = SAMPLE_BITS - 1;
    localparam logic [TABLE_ADDR_BITS:0] QUARTER_N =
        (TABLE_ADDR_BITS + 1)'(1) << TABLE_ADDR_BITS;

    // Configuration registers.
    logic [stg_pkg::CFG_WIDTH-1:0] r_phase_step;
    logic [stg_pkg::CFG_WIDTH-1:0] r_burst_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= '0;
            r_burst_length <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (stg_pkg::t_cfg_index'(i_cfg_idx))
                stg_pkg::CFG_PHASE_STEP:   r_phase_step   <= i_cfg_wdata;
                stg_pkg::CFG_BURST_LENGTH: r_burst_length <= i_cfg_wdata;
                default:                   r_phase_step   <= r_phase_step;
            endcase
        end
    end

    // Pipeline handshake.
    logic r_v1;
    logic r_v2;
    logic accept;
    logic s1_free;
    logic s2_load;
    logic take;

    assign take    = r_v2 && !i_stall;
    assign s2_load = r_v1 && (!r_v2 || !i_stall);
    assign s1_free = !r_v1 || s2_load;
    assign accept  = i_valid && s1_free;
    assign o_stall = !s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (s2_load) begin
                r_v1 <= 1'b0;
            end
            if (s2_load) begin
                r_v2 <= 1'b1;
            end else if (take) begin
                r_v2 <= 1'b0;
            end
        end
    end

    // Burst counter.
    logic [31:0] r_count;
    logic [31:0] cur_count;
    logic [32:0] count_inc;
    logic        last;

    assign cur_count = i_restart ? '0 : r_count;
    assign count_inc = {1'b0, cur_count} + 33'd1;
    assign last      = (r_burst_length != '0) && (count_inc >= {1'b0, r_burst_length});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= last ? '0 : count_inc[31:0];
        end
    end

    // Phase step fitted to the accumulator; step bits above it always wrap.
    logic [PHASE_BITS-1:0] step_ext;
    logic                  step_hi;

    if (PHASE_BITS >= stg_pkg::CFG_WIDTH) begin : g_step_wide
        assign step_ext = PHASE_BITS'(r_phase_step);
        assign step_hi  = 1'b0;
    end else begin : g_step_narrow
        assign step_ext = r_phase_step[PHASE_BITS-1:0];
        assign step_hi  = |r_phase_step[stg_pkg::CFG_WIDTH-1:PHASE_BITS];
    end

    // Row of accumulator cells, carry rippling from the low cell upward.
    stg_pkg::t_cell_ctl    cell_ctl;
    logic [NCELLS:0]       carry;
    logic [PHASE_BITS-1:0] cur_phase;

    assign cell_ctl.load  = accept;
    assign cell_ctl.clear = i_restart;
    assign cell_ctl.zero  = last;
    assign carry[0]       = 1'b0;

    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        localparam int LO = i * CW;
        localparam int W  = (PHASE_BITS - LO >= CW) ? CW : PHASE_BITS - LO;
        stg_phase_cell #(
            .W (W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl),
            .i_step  (step_ext[LO +: W]),
            .i_carry (carry[i]),
            .o_carry (carry[i+1]),
            .o_phase (cur_phase[LO +: W])
        );
    end

    // Quadrant and table address from the top phase bits.
    logic [1:0]               quad;
    logic [TABLE_ADDR_BITS:0] idx;
    logic [TABLE_ADDR_BITS:0] rom_addr;

    assign quad     = cur_phase[PHASE_BITS-1 -: 2];
    assign idx      = {1'b0, cur_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS]};
    assign rom_addr = quad[0] ? (QUARTER_N - idx) : idx;

    logic [MAG_W-1:0] rom_mag;

    stg_quarter_rom #(
        .ADDR_BITS (TABLE_ADDR_BITS),
        .DATA_BITS (MAG_W)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rd_en (accept),
        .i_addr  (rom_addr),
        .o_data  (rom_mag)
    );

    // Stage 1 side flags, aligned with the ROM read data.
    logic r_s1_neg;
    logic r_s1_cyc;
    logic r_s1_last;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_neg  <= quad[1];
            r_s1_cyc  <= carry[NCELLS] | step_hi;
            r_s1_last <= last;
        end
    end

    // Output register: sign applied to the magnitude.
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_cycle_end;
    logic                          r_last;
    logic signed [SAMPLE_BITS-1:0] mag_s;

    assign mag_s = signed'({1'b0, rom_mag});

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_sample    <= r_s1_neg ? -mag_s : mag_s;
            r_cycle_end <= r_s1_cyc;
            r_last      <= r_s1_last;
        end
    end

    assign o_valid     = r_v2;
    assign o_sample    = r_sample;
    assign o_cycle_end = r_cycle_end;
    assign o_last      = r_last;

endmodule

[rtl/stg_phase_cell.sv]
// One slice of the phase accumulator: holds W phase bits and ripples its
// carry to the next cell. Depends on stg_pkg for the control struct.
module stg_phase_cell #(
    parameter int W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stg_pkg::t_cell_ctl i_ctl,
    input  logic [W-1:0]      i_step,
    input  logic              i_carry,
    output logic              o_carry,
    output logic [W-1:0]      o_phase
);

    logic [W-1:0] r_phase;
    logic [W-1:0] n_phase;
    logic [W-1:0] sum;

    // Phase used for this request, after a restart has cleared it.
    assign o_phase = i_ctl.clear ? '0 : r_phase;

    assign {o_carry, sum} = {1'b0, o_phase} + {1'b0, i_step} + {{W{1'b0}}, i_carry};

    assign n_phase = i_ctl.zero ? '0 : sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_ctl.load) begin
            r_phase <= n_phase;
        end
    end

endmodule

[rtl/stg_quarter_rom.sv]
// Quarter-wave sine ROM with registered read, 2^ADDR_BITS + 1 entries.
// Contents are built at elaboration from stg_pkg::quarter_entry.
module stg_quarter_rom #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS:0]   i_addr,
    output logic [DATA_BITS-1:0] o_data
);

    localparam int DEPTH = (1 << ADDR_BITS) + 1;
    localparam logic [63:0] AMP = (64'd1 << DATA_BITS) - 64'd1;

    typedef logic [DEPTH-1:0][DATA_BITS-1:0] t_rom;

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k < DEPTH; k++) begin
            rom[k] = DATA_BITS'(stg_pkg::quarter_entry(32'(k), ADDR_BITS, AMP));
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [DATA_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

[sim/stg_tone_checker.sv]
// Scoreboard for the sine tone generator: watches the config port and both channels,
// predicts each tone sample and compares it with what the block delivers.
// Depends on stg_pkg for the register index names.
`timescale 1ns / 100ps

module stg_tone_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic        i_restart,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_stall,
    input  logic [15:0] i_sample,
    input  logic        i_cycle_end,
    input  logic        i_last,
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int          QTR_N         = 1024;
    localparam logic [63:0] QTR_TURN_Q30  = 64'd1686629713;
    localparam logic [63:0] FULL_SCALE    = 64'd32767;

    typedef struct packed {
        logic signed [15:0] level;
        logic               wrapped;
        logic               burst_end;
    } t_tone;

    logic signed [15:0] quarter_wave [0:QTR_N];
    t_tone              tone_q[$];

    logic [31:0] step_reg;
    logic [31:0] burst_reg;
    logic [31:0] phase_acc;
    logic [31:0] burst_count;
    int          fail_cnt = 0;
    int          pend_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pend_cnt;

    // Quarter-wave entry from a Q30 Taylor series of sin(pi/2 * k / N), rounded to
    // full scale. Each odd power is built from the previous one by two multiplies.
    function automatic logic signed [15:0] sine_entry(input logic [31:0] k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        divisor;
        logic signed [63:0] acc;
        logic signed [63:0] scaled;
        x    = (QTR_TURN_Q30 * {32'd0, k}) >> 10;
        term = x;
        acc  = $signed(x);
        for (int n = 1; n <= 7; n++) begin
            term    = (term * x) >> 30;
            term    = (term * x) >> 30;
            divisor = 64'(2 * n * (2 * n + 1));
            term    = term / divisor;
            if (n % 2 == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0) begin
            acc = 64'sd0;
        end
        scaled = (acc * $signed(FULL_SCALE) + (64'sd1 <<< 29)) >>> 30;
        if (scaled > $signed(FULL_SCALE)) begin
            scaled = $signed(FULL_SCALE);
        end
        return scaled[15:0];
    endfunction

    // Top two phase bits pick the quadrant, the next ten index the quarter table.
    function automatic logic signed [15:0] wave_at(input logic [31:0] ph);
        logic [9:0]         idx;
        logic signed [15:0] mag;
        idx = ph[29:20];
        if (ph[30]) begin
            mag = quarter_wave[11'd1024 - {1'b0, idx}];
        end else begin
            mag = quarter_wave[idx];
        end
        return ph[31] ? -mag : mag;
    endfunction

    task automatic predict_tone(input logic restart);
        t_tone       tone;
        logic [32:0] sum;
        if (restart) begin
            phase_acc   = '0;
            burst_count = '0;
        end
        tone.level     = wave_at(phase_acc);
        sum            = {1'b0, phase_acc} + {1'b0, step_reg};
        tone.wrapped   = sum[32];
        phase_acc      = sum[31:0];
        tone.burst_end = (burst_reg != 0) &&
                         ({1'b0, burst_count} + 33'd1 >= {1'b0, burst_reg});
        burst_count    = burst_count + 32'd1;
        if (tone.burst_end) begin
            phase_acc   = '0;
            burst_count = '0;
        end
        tone_q.push_back(tone);
    endtask

    task automatic report_mismatch(input string what, input t_tone want);
        if (fail_cnt < 10) begin
            $display("%0t: %s: expected level %0d wrap %0b last %0b, %s %0d wrap %0b last %0b",
                     $realtime, what, want.level, want.wrapped, want.burst_end,
                     "got level", $signed(i_sample), i_cycle_end, i_last);
        end
        fail_cnt = fail_cnt + 1;
    endtask

    initial begin
        for (int k = 0; k <= QTR_N; k++) begin
            quarter_wave[k] = sine_entry(32'(k));
        end
    end

    always @(posedge i_clk) begin
        t_tone want;
        if (!i_rst_n) begin
            step_reg    = '0;
            burst_reg   = '0;
            phase_acc   = '0;
            burst_count = '0;
            tone_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (stg_pkg::t_cfg_index'(i_cfg_idx))
                    stg_pkg::CFG_PHASE_STEP: begin
                        step_reg = i_cfg_wdata;
                    end
                    stg_pkg::CFG_BURST_LENGTH: begin
                        burst_reg = i_cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (tone_q.size() == 0) begin
                    want = '0;
                    report_mismatch("sample with no request outstanding", want);
                end else begin
                    want = tone_q.pop_front();
                    if (want.level !== $signed(i_sample) || want.wrapped !== i_cycle_end ||
                        want.burst_end !== i_last) begin
                        report_mismatch("sample mismatch", want);
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                predict_tone(i_restart);
            end
        end
        pend_cnt = tone_q.size();
    end

endmodule

[sim/testbench.sv]
// Top of the sine tone generator test: clock, reset, register setup, request
// stimulus with random gaps and output back-pressure. Depends on stg_pkg,
// sine_tone_generator and stg_tone_checker.
`timescale 1ns / 100ps

module testbench;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_restart   = 1'b0;
    logic        i_stall     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [0:0]  i_cfg_idx   = stg_pkg::CFG_PHASE_STEP;
    logic [31:0] i_cfg_wdata = '0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_sample;
    logic        o_cycle_end;
    logic        o_last;

    int   fail_count;
    int   pending;
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   stall_mode = 0;
    int   mode_left  = 0;

    always #10 i_clk = ~i_clk;

    sine_tone_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sample    (o_sample),
        .o_cycle_end (o_cycle_end),
        .o_last      (o_last),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    stg_tone_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_restart    (i_restart),
        .i_rsp_valid  (o_valid),
        .i_rsp_stall  (i_stall),
        .i_sample     (o_sample),
        .i_cycle_end  (o_cycle_end),
        .i_last       (o_last),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Output back-pressure: segments of no stall, random stall, toggling and
    // heavy stall. A rising hold_req starts one long hold-off instead.
    always @(posedge i_clk) begin
        if (hold_req && !hold_seen) begin
            hold_left = 400;
        end
        hold_seen = hold_req;
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(3);
                mode_left  = $urandom_range(80, 8);
            end
            mode_left = mode_left - 1;
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(99) < 30);
                2: i_stall <= ~i_stall;
                default: i_stall <= ($urandom_range(3) != 0);
            endcase
        end
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    // The stall is looked at mid-cycle, where it is settled.
    task automatic send_request(input logic restart);
        i_valid   <= 1'b1;
        i_restart <= restart;
        @(negedge i_clk);
        while (o_stall) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // Lets every outstanding sample drain, then writes both registers.
    task automatic write_regs(input logic [31:0] step, input logic [31:0] burst);
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= stg_pkg::CFG_PHASE_STEP;
        i_cfg_wdata <= step;
        @(posedge i_clk);
        i_cfg_idx   <= stg_pkg::CFG_BURST_LENGTH;
        i_cfg_wdata <= burst;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_run(input int count, input int restart_pct, input logic gaps);
        int run_left;
        run_left = $urandom_range(30, 1);
        for (int n = 0; n < count; n++) begin
            if (gaps && run_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(8, 1)) @(posedge i_clk);
                run_left = $urandom_range(30, 1);
            end
            run_left = run_left - 1;
            send_request($urandom_range(99) < restart_pct);
        end
    endtask

    initial begin
        logic [31:0] step;
        logic [31:0] burst;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers still at reset: zero step gives a constant output.
        send_request(1'b0);
        send_request(1'b1);
        // Quarter-turn step walks all four quadrants and wraps.
        write_regs(32'h4000_0000, 32'd0);
        repeat (5) send_request(1'b0);
        send_request(1'b1);
        // Largest step with a two-sample burst: the wrap lands on the last sample.
        write_regs(32'hFFFF_FFFF, 32'd2);
        repeat (3) send_request(1'b0);
        // Burst length lowered below the running count ends the burst at once.
        write_regs(32'h00A3_D70A, 32'd0);
        repeat (6) send_request(1'b0);
        write_regs(32'h00A3_D70A, 32'd3);
        repeat (2) send_request(1'b0);
        // A burst of one flags every sample; then the longest burst.
        write_regs(32'h1234_5678, 32'd1);
        repeat (3) send_request(1'b0);
        write_regs(32'h8000_0000, 32'hFFFF_FFFF);
        repeat (3) send_request(1'b0);

        for (int ph = 0; ph < 11; ph++) begin
            case ($urandom_range(4))
                0: step = 32'd0;
                1: step = 32'hFFFF_FFFF;
                2: step = 32'(33'h1_0000_0000 / $urandom_range(2000, 2));
                3: step = $urandom;
                default: step = $urandom_range(65535, 1);
            endcase
            case ($urandom_range(4))
                0: burst = 32'd0;
                1: burst = 32'd1;
                2: burst = $urandom_range(40, 2);
                3: burst = 32'hFFFF_FFFF;
                default: burst = $urandom;
            endcase
            write_regs(step, burst);
            if (ph == 5) begin
                // Long output hold-off while requests keep coming, to fill the block.
                hold_req <= 1'b1;
                send_run($urandom_range(130, 80), 6, 1'b0);
            end else begin
                send_run($urandom_range(130, 80), 6, 1'b1);
            end
        end

        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/stg_pkg.sv
rtl/stg_phase_cell.sv
rtl/stg_quarter_rom.sv
rtl/sine_tone_generator.sv
sim/stg_tone_checker.sv
sim/testbench.sv
